// ----- src/eab_pkg.sv -----
`timescale 1ns / 1ps

package eab_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   localparam int ANG_W = 16;
   localparam int OUT_W = 16;

   localparam int CORDIC_ITERS = 30;
   localparam int Q            = 30;

   localparam int XY_W   = 33;
   localparam int Z_W    = 34;
   localparam int SC_W   = 32;
   localparam int PROD_W = 2 * SC_W;
   localparam int V_W    = 33;

   localparam logic signed [XY_W-1:0] CORDIC_K = 33'sd652032874;
   localparam logic signed [XY_W-1:0] XY_ONE   = 33'sd1 <<< Q;

   localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_ITERS-1] = '{
      34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
      34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
      34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2F9,
      34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
      34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
      34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } cordic_type;

   // undo the half-turn fold, then saturate to +/-1.0
   function automatic logic signed [SC_W-1:0] fold_clamp(input logic signed [XY_W-1:0] v,
                                                         input logic flip);
      logic signed [XY_W-1:0] f;
      f = flip ? -v : v;
      if (f > XY_ONE) begin
         f = XY_ONE;
      end else if (f < -XY_ONE) begin
         f = -XY_ONE;
      end
      return f[SC_W-1:0];
   endfunction

   // Q30 product back to Q30, round half up
   function automatic logic signed [SC_W-1:0] mul_rnd(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + (PROD_W'(1) <<< (Q - 1));
      return s[Q+SC_W-1:Q];
   endfunction

endpackage

// ----- src/euler_angles_to_basis.sv -----
`timescale 1ns / 1ps
// Euler angles to forward / right / up basis vectors.
// Input: pulse start with req_yaw, req_pitch, req_roll (binary angles, one turn
// is 2^ANGLE_BITS). busy is tied low, so a beat is taken on every cycle start
// is high.
// Output: rsp_valid is high for one cycle with the nine Q1.FRAC_BITS components
// rsp_forward_*, rsp_right_*, rsp_up_*, saturated to +/-1.0. The receiver
// cannot stall and must take the beat in that cycle.
// Throughput: one beat per cycle, fully pipelined.
// Pipeline: one entry stage that folds the angle into +/-90 degrees, 30 CORDIC
// stages (one micro-rotation each, yaw/pitch/roll in parallel lanes), then
// unfold/saturate, two multiply/round pairs, a sum stage and the output stage.
// Each stage holds at most one 32x32 multiply or one wide add per path, which sets the clock.
// Reset clears the valid bits only; beats in flight are dropped.
module euler_angles_to_basis #(
   parameter int ANGLE_BITS = eab_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = eab_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic        [eab_pkg::ANG_W-1:0] req_yaw,
   input  logic        [eab_pkg::ANG_W-1:0] req_pitch,
   input  logic        [eab_pkg::ANG_W-1:0] req_roll,
   output logic                             rsp_valid,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_forward_x,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_forward_y,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_forward_z,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_right_x,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_right_y,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_right_z,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_up_x,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_up_y,
   output logic signed [eab_pkg::OUT_W-1:0] rsp_up_z
);

   import eab_pkg::*;

   localparam int NSTAGE = CORDIC_ITERS + 8;
   localparam int SH     = Q - FRAC_BITS;
   localparam int OV_W   = V_W + 2;
   localparam logic signed [OV_W-1:0] OUT_LIM = OV_W'(1) <<< FRAC_BITS;
   localparam logic signed [OV_W-1:0] OUT_RND = OV_W'(1) <<< SH;

   // lanes
   localparam int L_YAW = 0;
   localparam int L_PIT = 1;
   localparam int L_ROL = 2;

   // first product stage
   localparam int P_T  = 0;
   localparam int P_U  = 1;
   localparam int P_FX = 2;
   localparam int P_FY = 3;
   localparam int P_RZ = 4;
   localparam int P_UZ = 5;
   localparam int P_RB = 6;
   localparam int P_RD = 7;
   localparam int P_UB = 8;
   localparam int P_UD = 9;

   // second product stage
   localparam int Q_TCY = 0;
   localparam int Q_TSY = 1;
   localparam int Q_UCY = 2;
   localparam int Q_USY = 3;

   // terms carried past the second products
   localparam int K_FX = 0;
   localparam int K_FY = 1;
   localparam int K_RZ = 2;
   localparam int K_UZ = 3;
   localparam int K_RB = 4;
   localparam int K_RD = 5;
   localparam int K_UB = 6;
   localparam int K_UD = 7;

   // outputs
   localparam int O_FX = 0;
   localparam int O_FY = 1;
   localparam int O_FZ = 2;
   localparam int O_RX = 3;
   localparam int O_RY = 4;
   localparam int O_RZ = 5;
   localparam int O_UX = 6;
   localparam int O_UY = 7;
   localparam int O_UZ = 8;

   function automatic logic signed [OUT_W-1:0] out_q(input logic signed [V_W-1:0] v);
      logic signed [OV_W-1:0] t;
      logic signed [OV_W-1:0] r;
      t = (OV_W'(v) <<< 1) + OUT_RND;
      r = t >>> (SH + 1);
      if (r > OUT_LIM) begin
         r = OUT_LIM;
      end else if (r < -OUT_LIM) begin
         r = -OUT_LIM;
      end
      return r[OUT_W-1:0];
   endfunction

   logic [NSTAGE-1:0] vld_ff, vld_in;

   cordic_type cor_ff [0:CORDIC_ITERS][0:2];
   cordic_type cor_in [0:CORDIC_ITERS][0:2];

   logic signed [SC_W-1:0]   sc_s_ff [0:2], sc_s_in [0:2];
   logic signed [SC_W-1:0]   sc_c_ff [0:2], sc_c_in [0:2];

   logic signed [PROD_W-1:0] p1_ff [0:9], p1_in [0:9];
   logic signed [SC_W-1:0]   p1_sp_ff, p1_sp_in, p1_sy_ff, p1_sy_in, p1_cy_ff, p1_cy_in;

   logic signed [SC_W-1:0]   r1_ff [0:9], r1_in [0:9];
   logic signed [SC_W-1:0]   r1_sp_ff, r1_sp_in, r1_sy_ff, r1_sy_in, r1_cy_ff, r1_cy_in;

   logic signed [PROD_W-1:0] p2_ff [0:3], p2_in [0:3];
   logic signed [SC_W-1:0]   p2_keep_ff [0:7], p2_keep_in [0:7];
   logic signed [SC_W-1:0]   p2_sp_ff, p2_sp_in;

   logic signed [SC_W-1:0]   r2_ff [0:3], r2_in [0:3];
   logic signed [SC_W-1:0]   r2_keep_ff [0:7], r2_keep_in [0:7];
   logic signed [SC_W-1:0]   r2_sp_ff, r2_sp_in;

   logic signed [V_W-1:0]    sum_ff [0:8], sum_in [0:8];
   logic signed [OUT_W-1:0]  out_ff [0:8], out_in [0:8];

   logic [ANG_W-1:0] ang [0:2];

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[NSTAGE-2:0], start};

   assign ang[L_YAW] = req_yaw;
   assign ang[L_PIT] = req_pitch;
   assign ang[L_ROL] = req_roll;

   // entry: binary angle to 32-bit phase, fold into +/-90 degrees
   always_comb begin
      logic [31:0] ph;
      for (int l = 0; l < 3; l++) begin
         ph = 32'(ang[l]) << (32 - ANGLE_BITS);
         cor_in[0][l].flip = ph[31] ^ ph[30];
         if (ph[31] ^ ph[30]) begin
            ph[31] = ~ph[31];
         end
         cor_in[0][l].x = CORDIC_K;
         cor_in[0][l].y = '0;
         cor_in[0][l].z = Z_W'($signed(ph));
      end
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
      always_comb begin
         logic signed [XY_W-1:0] dx;
         logic signed [XY_W-1:0] dy;
         for (int l = 0; l < 3; l++) begin
            dx = cor_ff[i][l].y >>> i;
            dy = cor_ff[i][l].x >>> i;
            cor_in[i+1][l].flip = cor_ff[i][l].flip;
            if (!cor_ff[i][l].z[Z_W-1]) begin
               cor_in[i+1][l].x = cor_ff[i][l].x - dx;
               cor_in[i+1][l].y = cor_ff[i][l].y + dy;
               cor_in[i+1][l].z = cor_ff[i][l].z - ATAN_TAB[i];
            end else begin
               cor_in[i+1][l].x = cor_ff[i][l].x + dx;
               cor_in[i+1][l].y = cor_ff[i][l].y - dy;
               cor_in[i+1][l].z = cor_ff[i][l].z + ATAN_TAB[i];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sc_c_in[l] = fold_clamp(cor_ff[CORDIC_ITERS][l].x, cor_ff[CORDIC_ITERS][l].flip);
         sc_s_in[l] = fold_clamp(cor_ff[CORDIC_ITERS][l].y, cor_ff[CORDIC_ITERS][l].flip);
      end
   end

   // first products
   always_comb begin
      logic signed [PROD_W-1:0] sy, cy, sp, cp, sr, cr;
      sy = PROD_W'(sc_s_ff[L_YAW]);
      cy = PROD_W'(sc_c_ff[L_YAW]);
      sp = PROD_W'(sc_s_ff[L_PIT]);
      cp = PROD_W'(sc_c_ff[L_PIT]);
      sr = PROD_W'(sc_s_ff[L_ROL]);
      cr = PROD_W'(sc_c_ff[L_ROL]);
      p1_in[P_T]  = sr * sp;
      p1_in[P_U]  = cr * sp;
      p1_in[P_FX] = cp * cy;
      p1_in[P_FY] = cp * sy;
      p1_in[P_RZ] = sr * cp;
      p1_in[P_UZ] = cr * cp;
      p1_in[P_RB] = cr * sy;
      p1_in[P_RD] = cr * cy;
      p1_in[P_UB] = sr * sy;
      p1_in[P_UD] = sr * cy;
      p1_sp_in = sc_s_ff[L_PIT];
      p1_sy_in = sc_s_ff[L_YAW];
      p1_cy_in = sc_c_ff[L_YAW];
   end

   always_comb begin
      for (int k = 0; k < 10; k++) begin
         r1_in[k] = mul_rnd(p1_ff[k]);
      end
      r1_sp_in = p1_sp_ff;
      r1_sy_in = p1_sy_ff;
      r1_cy_in = p1_cy_ff;
   end

   // second products
   always_comb begin
      p2_in[Q_TCY] = PROD_W'(r1_ff[P_T]) * PROD_W'(r1_cy_ff);
      p2_in[Q_TSY] = PROD_W'(r1_ff[P_T]) * PROD_W'(r1_sy_ff);
      p2_in[Q_UCY] = PROD_W'(r1_ff[P_U]) * PROD_W'(r1_cy_ff);
      p2_in[Q_USY] = PROD_W'(r1_ff[P_U]) * PROD_W'(r1_sy_ff);
      for (int k = 0; k < 8; k++) begin
         p2_keep_in[k] = r1_ff[k + P_FX];
      end
      p2_sp_in = r1_sp_ff;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r2_in[k] = mul_rnd(p2_ff[k]);
      end
      r2_keep_in = p2_keep_ff;
      r2_sp_in   = p2_sp_ff;
   end

   always_comb begin
      sum_in[O_FX] = V_W'(r2_keep_ff[K_FX]);
      sum_in[O_FY] = V_W'(r2_keep_ff[K_FY]);
      sum_in[O_FZ] = -V_W'(r2_sp_ff);
      sum_in[O_RX] = V_W'(r2_keep_ff[K_RB]) - V_W'(r2_ff[Q_TCY]);
      sum_in[O_RY] = -V_W'(r2_ff[Q_TSY]) - V_W'(r2_keep_ff[K_RD]);
      sum_in[O_RZ] = -V_W'(r2_keep_ff[K_RZ]);
      sum_in[O_UX] = V_W'(r2_ff[Q_UCY]) + V_W'(r2_keep_ff[K_UB]);
      sum_in[O_UY] = V_W'(r2_ff[Q_USY]) - V_W'(r2_keep_ff[K_UD]);
      sum_in[O_UZ] = V_W'(r2_keep_ff[K_UZ]);
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         out_in[k] = out_q(sum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cor_ff     <= cor_in;
      sc_s_ff    <= sc_s_in;
      sc_c_ff    <= sc_c_in;
      p1_ff      <= p1_in;
      p1_sp_ff   <= p1_sp_in;
      p1_sy_ff   <= p1_sy_in;
      p1_cy_ff   <= p1_cy_in;
      r1_ff      <= r1_in;
      r1_sp_ff   <= r1_sp_in;
      r1_sy_ff   <= r1_sy_in;
      r1_cy_ff   <= r1_cy_in;
      p2_ff      <= p2_in;
      p2_keep_ff <= p2_keep_in;
      p2_sp_ff   <= p2_sp_in;
      r2_ff      <= r2_in;
      r2_keep_ff <= r2_keep_in;
      r2_sp_ff   <= r2_sp_in;
      sum_ff     <= sum_in;
      out_ff     <= out_in;
   end

   assign rsp_valid     = vld_ff[NSTAGE-1];
   assign rsp_forward_x = out_ff[O_FX];
   assign rsp_forward_y = out_ff[O_FY];
   assign rsp_forward_z = out_ff[O_FZ];
   assign rsp_right_x   = out_ff[O_RX];
   assign rsp_right_y   = out_ff[O_RY];
   assign rsp_right_z   = out_ff[O_RZ];
   assign rsp_up_x      = out_ff[O_UX];
   assign rsp_up_y      = out_ff[O_UY];
   assign rsp_up_z      = out_ff[O_UZ];

endmodule
